// File: hdl/websocket_frame_unmasker_defines.svh
// ----------------------------------------------------------------------------
// WebSocket frame unmasker assertion macros
// Concurrent assertion forms used by the unmasker parser.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker package
// Phase and result kind codes, header constants and the result record.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    // Parser phases of a client-to-server frame.
    typedef enum logic [2:0] {
        PH_B0  = 3'd0,
        PH_B1  = 3'd1,
        PH_EXT = 3'd2,
        PH_KEY = 3'd3,
        PH_PAY = 3'd4,
        PH_ERR = 3'd5
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_RSV_ERR   = 2'd2,
        KIND_UNMASKED  = 2'd3
    } kind_t;

    // Header field constants.
    localparam logic [7:0] RSV_MASK       = 8'h70;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [1:0] KEY_LAST_INDEX = 2'd3;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic [63:0] payload_length;
        logic [7:0]  out_byte;
        logic        last;
    } result_t;

endpackage

// File: hdl/wsfu_in_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker input channel
// Valid/ready channel that carries one raw frame byte per transfer.
// ----------------------------------------------------------------------------
interface wsfu_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

// File: hdl/wsfu_out_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker result channel
// Valid/ready channel that carries one header, payload or error result.
// ----------------------------------------------------------------------------
interface wsfu_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [63:0] payload_length;
    logic [7:0]  out_byte;
    logic        last;

    modport source (
        output valid, output kind, output fin, output opcode,
        output payload_length, output out_byte, output last,
        input  ready
    );
    modport sink (
        input  valid, input kind, input fin, input opcode,
        input  payload_length, input out_byte, input last,
        output ready
    );

endinterface

// File: hdl/websocket_frame_unmasker.sv
// A transferred byte is held in the input register, and its result is registered in the result register.
// Throughput: one byte per cycle; the input and result registers both drain and fill
// in the same cycle, so only result backpressure slows the stream.
// Reset: rst_n clears the parser to expect a new frame header and empties both
// registers; after a reserved-bit or unmasked error, only reset resumes parsing.
// ----------------------------------------------------------------------------
// WebSocket frame unmasker
// Parses client-to-server frame headers and unmasks the payload byte stream.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
    input  logic       clk,
    input  logic       rst_n,
    wsfu_in_if.sink    frame,
    wsfu_out_if.source result
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              out_free;
    logic              step;
    logic              res_valid;
    wsfu_pkg::result_t res;

    // A held byte is processed whenever the result register can take its result.
    assign step = held_valid && out_free;

    wsfu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wsfu_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .result    (result)
    );

endmodule

// File: hdl/wsfu_in_reg.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker input register
// Captures one incoming byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module wsfu_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    wsfu_in_if.sink    frame,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // The register accepts a transfer when it is empty or drains this cycle.
    assign frame.ready = !valid_reg || take;
    assign load        = frame.valid && frame.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= frame.in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// File: hdl/wsfu_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker parser
// Header parsing state, masking key and payload unmasking for one byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_unmasker_defines.svh"

module wsfu_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output logic              res_valid,
    output wsfu_pkg::result_t res
);

    wsfu_pkg::phase_t phase_reg;
    wsfu_pkg::phase_t phase_next;
    logic             fin_flag_reg;
    logic             fin_flag_next;
    logic [3:0]       frame_opcode_reg;
    logic [3:0]       frame_opcode_next;
    logic [3:0]       ext_bytes_left_reg;
    logic [3:0]       ext_bytes_left_next;
    logic [63:0]      frame_length_reg;
    logic [63:0]      frame_length_next;
    logic [31:0]      mask_key_reg;
    logic [31:0]      mask_key_next;
    logic [1:0]       key_index_reg;
    logic [1:0]       key_index_next;
    logic [63:0]      bytes_remaining_reg;
    logic [63:0]      bytes_remaining_next;

    logic [6:0]       len7;
    logic [1:0]       key_sel;
    logic [7:0]       key_byte;
    logic             last_payload;
    logic             key_done;

    assign len7         = in_byte[6:0];
    // Key bytes are stored first byte in the top bits, so index k picks byte 3-k.
    assign key_sel      = ~key_index_reg;
    assign key_byte     = mask_key_reg[{key_sel, 3'b000} +: 8];
    assign last_payload = (bytes_remaining_reg == 64'd1);
    assign key_done     = (key_index_reg == wsfu_pkg::KEY_LAST_INDEX);

    // Next phase of the frame parser.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                wsfu_pkg::PH_B0:
                begin
                    if ((in_byte & wsfu_pkg::RSV_MASK) != 8'd0)
                    begin
                        phase_next = wsfu_pkg::PH_ERR;
                    end
                    else
                    begin
                        phase_next = wsfu_pkg::PH_B1;
                    end
                end
                wsfu_pkg::PH_B1:
                begin
                    if (!in_byte[7])
                    begin
                        phase_next = wsfu_pkg::PH_ERR;
                    end
                    else if (len7 == wsfu_pkg::LEN_CODE_EXT16 ||
                             len7 == wsfu_pkg::LEN_CODE_EXT64)
                    begin
                        phase_next = wsfu_pkg::PH_EXT;
                    end
                    else
                    begin
                        phase_next = wsfu_pkg::PH_KEY;
                    end
                end
                wsfu_pkg::PH_EXT:
                begin
                    if (ext_bytes_left_reg == 4'd1)
                    begin
                        phase_next = wsfu_pkg::PH_KEY;
                    end
                end
                wsfu_pkg::PH_KEY:
                begin
                    if (key_done)
                    begin
                        if (frame_length_reg == 64'd0)
                        begin
                            phase_next = wsfu_pkg::PH_B0;
                        end
                        else
                        begin
                            phase_next = wsfu_pkg::PH_PAY;
                        end
                    end
                end
                wsfu_pkg::PH_PAY:
                begin
                    if (last_payload)
                    begin
                        phase_next = wsfu_pkg::PH_B0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Frame fields, key and counters, and the result of the current byte.
    always_comb
    begin
        fin_flag_next        = fin_flag_reg;
        frame_opcode_next    = frame_opcode_reg;
        ext_bytes_left_next  = ext_bytes_left_reg;
        frame_length_next    = frame_length_reg;
        mask_key_next        = mask_key_reg;
        key_index_next       = key_index_reg;
        bytes_remaining_next = bytes_remaining_reg;
        res_valid            = 1'b0;
        res.kind             = wsfu_pkg::KIND_HEADER;
        res.fin              = fin_flag_reg;
        res.opcode           = frame_opcode_reg;
        res.payload_length   = 64'd0;
        res.out_byte         = 8'd0;
        res.last             = 1'b0;
        if (step)
        begin
            case (phase_reg)
                wsfu_pkg::PH_B0:
                begin
                    fin_flag_next     = in_byte[7];
                    frame_opcode_next = in_byte[3:0];
                    if ((in_byte & wsfu_pkg::RSV_MASK) != 8'd0)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = wsfu_pkg::KIND_RSV_ERR;
                        res.fin    = in_byte[7];
                        res.opcode = in_byte[3:0];
                    end
                end
                wsfu_pkg::PH_B1:
                begin
                    if (!in_byte[7])
                    begin
                        res_valid = 1'b1;
                        res.kind  = wsfu_pkg::KIND_UNMASKED;
                    end
                    else
                    begin
                        key_index_next = 2'd0;
                        mask_key_next  = 32'd0;
                        if (len7 == wsfu_pkg::LEN_CODE_EXT16)
                        begin
                            frame_length_next   = 64'd0;
                            ext_bytes_left_next = wsfu_pkg::EXT16_BYTES;
                        end
                        else if (len7 == wsfu_pkg::LEN_CODE_EXT64)
                        begin
                            frame_length_next   = 64'd0;
                            ext_bytes_left_next = wsfu_pkg::EXT64_BYTES;
                        end
                        else
                        begin
                            frame_length_next   = {57'd0, len7};
                            ext_bytes_left_next = 4'd0;
                        end
                    end
                end
                wsfu_pkg::PH_EXT:
                begin
                    frame_length_next   = {frame_length_reg[55:0], in_byte};
                    ext_bytes_left_next = ext_bytes_left_reg - 4'd1;
                end
                wsfu_pkg::PH_KEY:
                begin
                    mask_key_next  = {mask_key_reg[23:0], in_byte};
                    key_index_next = key_index_reg + 2'd1;
                    if (key_done)
                    begin
                        bytes_remaining_next = frame_length_reg;
                        res_valid            = 1'b1;
                        res.kind             = wsfu_pkg::KIND_HEADER;
                        res.payload_length   = frame_length_reg;
                        res.last             = (frame_length_reg == 64'd0);
                    end
                end
                wsfu_pkg::PH_PAY:
                begin
                    bytes_remaining_next = bytes_remaining_reg - 64'd1;
                    res_valid            = 1'b1;
                    res.kind             = wsfu_pkg::KIND_PAYLOAD;
                    res.payload_length   = frame_length_reg;
                    res.out_byte         = in_byte ^ key_byte;
                    res.last             = last_payload;
                    if (last_payload)
                    begin
                        key_index_next = 2'd0;
                    end
                    else
                    begin
                        key_index_next = key_index_reg + 2'd1;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= wsfu_pkg::PH_B0;
            fin_flag_reg        <= 1'b0;
            frame_opcode_reg    <= 4'd0;
            ext_bytes_left_reg  <= 4'd0;
            frame_length_reg    <= 64'd0;
            mask_key_reg        <= 32'd0;
            key_index_reg       <= 2'd0;
            bytes_remaining_reg <= 64'd0;
        end
        else
        begin
            phase_reg           <= phase_next;
            fin_flag_reg        <= fin_flag_next;
            frame_opcode_reg    <= frame_opcode_next;
            ext_bytes_left_reg  <= ext_bytes_left_next;
            frame_length_reg    <= frame_length_next;
            mask_key_reg        <= mask_key_next;
            key_index_reg       <= key_index_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    // An error is sticky until reset.
    `WSFU_ASSERT_NEXT(a_err_sticky, phase_reg == wsfu_pkg::PH_ERR,
        phase_reg == wsfu_pkg::PH_ERR, "parser left the error phase")
    // Nothing is produced once the stream is rejected.
    `WSFU_ASSERT_SAME(a_err_silent, phase_reg == wsfu_pkg::PH_ERR,
        !res_valid, "result produced in the error phase")
    // The payload phase always has at least one byte to go.
    `WSFU_ASSERT_SAME(a_pay_nonzero, phase_reg == wsfu_pkg::PH_PAY,
        bytes_remaining_reg != 64'd0, "payload phase with no bytes left")
    // Each new frame starts with the key rotation at its first byte.
    `WSFU_ASSERT_SAME(a_key_aligned, phase_reg == wsfu_pkg::PH_B0,
        key_index_reg == 2'd0, "key index not aligned at frame start")

endmodule

// File: hdl/wsfu_out_reg.sv
// ----------------------------------------------------------------------------
// WebSocket frame unmasker result register
// Holds one result until the result channel completes its transfer.
// ----------------------------------------------------------------------------
module wsfu_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  wsfu_pkg::result_t res,
    output logic              free,
    wsfu_out_if.source        result
);

    logic              valid_reg;
    logic              valid_next;
    wsfu_pkg::result_t res_reg;

    // The register can take a new result when empty or being drained.
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = res_reg.kind;
    assign result.fin            = res_reg.fin;
    assign result.opcode         = res_reg.opcode;
    assign result.payload_length = res_reg.payload_length;
    assign result.out_byte       = res_reg.out_byte;
    assign result.last           = res_reg.last;

endmodule
